// ===== hw/rtl/etp_pkg.sv =====
// shared constants, types and tables for the ellipse trajectory point block
package etp_pkg;

    localparam int CORDIC_STEPS_DEF  = 16;
    localparam int POS_FRAC_BITS_DEF = 24;
    localparam int ATAN_LEN          = 31;
    localparam int FIFO_DEPTH        = 4;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    typedef struct packed {
        logic [31:0]        time_ms;
        logic [31:0]        turn_period;
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] center_z;
        logic signed [31:0] cos_axis_x;
        logic signed [31:0] cos_axis_y;
        logic signed [31:0] cos_axis_z;
        logic signed [31:0] sin_axis_x;
        logic signed [31:0] sin_axis_y;
        logic signed [31:0] sin_axis_z;
    } item_t;

    // classified word handed from front to back
    typedef struct packed {
        logic               fault;
        logic [31:0]        rem_ms;
        logic [31:0]        turn_period;
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] center_z;
        logic signed [31:0] cos_axis_x;
        logic signed [31:0] cos_axis_y;
        logic signed [31:0] cos_axis_z;
        logic signed [31:0] sin_axis_x;
        logic signed [31:0] sin_axis_y;
        logic signed [31:0] sin_axis_z;
    } task_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic               period_fault;
    } result_t;

    function automatic logic [31:0] atan_turn(input int i);
        logic [31:0] r;
        case (i)
            0: r = 32'd536870912;
            1: r = 32'd316933406;
            2: r = 32'd167458907;
            3: r = 32'd85004756;
            4: r = 32'd42667331;
            5: r = 32'd21354465;
            6: r = 32'd10679838;
            7: r = 32'd5340245;
            8: r = 32'd2670163;
            9: r = 32'd1335087;
            10: r = 32'd667544;
            11: r = 32'd333772;
            12: r = 32'd166886;
            13: r = 32'd83443;
            14: r = 32'd41722;
            15: r = 32'd20861;
            16: r = 32'd10430;
            17: r = 32'd5215;
            18: r = 32'd2608;
            19: r = 32'd1304;
            20: r = 32'd652;
            21: r = 32'd326;
            22: r = 32'd163;
            23: r = 32'd81;
            24: r = 32'd41;
            25: r = 32'd20;
            26: r = 32'd10;
            27: r = 32'd5;
            28: r = 32'd3;
            29: r = 32'd1;
            30: r = 32'd1;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== hw/rtl/etp_front.sv =====
// front end: pipelined restoring divide for time mod period, one bit per stage
module etp_front import etp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  item_t in_item,
    input  logic  advance,
    output logic  out_valid,
    output task_t out_task
);
    localparam int NS = 32;

    logic  [NS:0]    vld_reg;
    item_t           itm_reg [NS+1];
    logic  [31:0]    rem_reg [NS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (advance)
        begin
            vld_reg <= {vld_reg[NS-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            itm_reg[0] <= in_item;
            rem_reg[0] <= '0;
            for (int s = 0; s < NS; s++)
            begin
                logic [32:0] t;
                t = {rem_reg[s], itm_reg[s].time_ms[31-s]};
                if (t >= {1'b0, itm_reg[s].turn_period})
                begin
                    t = t - {1'b0, itm_reg[s].turn_period};
                end
                rem_reg[s+1] <= t[31:0];
                itm_reg[s+1] <= itm_reg[s];
            end
        end
    end

    assign out_valid = vld_reg[NS];

    always_comb
    begin
        out_task.fault       = (itm_reg[NS].turn_period == 32'd0);
        out_task.rem_ms      = rem_reg[NS];
        out_task.turn_period = itm_reg[NS].turn_period;
        out_task.center_x    = itm_reg[NS].center_x;
        out_task.center_y    = itm_reg[NS].center_y;
        out_task.center_z    = itm_reg[NS].center_z;
        out_task.cos_axis_x  = itm_reg[NS].cos_axis_x;
        out_task.cos_axis_y  = itm_reg[NS].cos_axis_y;
        out_task.cos_axis_z  = itm_reg[NS].cos_axis_z;
        out_task.sin_axis_x  = itm_reg[NS].sin_axis_x;
        out_task.sin_axis_y  = itm_reg[NS].sin_axis_y;
        out_task.sin_axis_z  = itm_reg[NS].sin_axis_z;
    end
endmodule

// ===== hw/rtl/etp_fifo.sv =====
// small word queue that decouples the front end from the back end
module etp_fifo import etp_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH,
    parameter int WIDTH = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]          mem [DEPTH];
    logic [AW-1:0]             wp_reg, rp_reg;
    logic [CW-1:0]             cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wp_reg <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + AW'(1);
            end
            if (rd_en)
            begin
                rp_reg <= (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + AW'(1);
            end
            cnt_reg <= cnt_reg + CW'(wr_en) - CW'(rd_en);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wp_reg] <= wr_data;
        end
    end

    assign rd_data = mem[rp_reg];
    assign empty   = (cnt_reg == '0);
    assign count   = cnt_reg;
endmodule

// ===== hw/rtl/etp_back.sv =====
// back end: phase divide, cordic pipeline, multiply-accumulate and saturation
module etp_back import etp_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  task_t   in_task,
    input  logic    advance,
    output logic    out_valid,
    output result_t out_res
);
    localparam int ND = 32;
    localparam int NC = CORDIC_STEPS;
    // divide stages, fold stage, cordic stages, round, two multiply stages, sum
    localparam int NT = ND + 1 + NC + 1 + 2 + 1;

    // payload carried alongside each stage
    task_t           tsk_reg [NT+1];
    logic [NT:0]     vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (advance)
        begin
            vld_reg <= {vld_reg[NT-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            tsk_reg[0] <= in_task;
            for (int s = 0; s < NT; s++)
            begin
                tsk_reg[s+1] <= tsk_reg[s];
            end
        end
    end

    // phase = (rem << 32) / period, one quotient bit per stage
    logic [32:0] drem_reg [ND+1];
    logic [31:0] quo_reg  [ND+1];

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            drem_reg[0] <= {1'b0, in_task.rem_ms};
            quo_reg[0]  <= '0;
            for (int s = 0; s < ND; s++)
            begin
                logic [33:0] t;
                logic        q;
                t = {drem_reg[s], 1'b0};
                q = (t >= {2'b0, tsk_reg[s].turn_period});
                if (q)
                begin
                    t = t - {2'b0, tsk_reg[s].turn_period};
                end
                drem_reg[s+1] <= t[32:0];
                quo_reg[s+1]  <= {quo_reg[s][30:0], q};
            end
        end
    end

    // quadrant fold and cordic rotation
    logic signed [33:0] cx_reg [NC+1];
    logic signed [33:0] cy_reg [NC+1];
    logic signed [33:0] cz_reg [NC+1];
    logic [NC:0]        flip_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            logic signed [33:0] z0;
            logic               fold;
            z0 = {{2{quo_reg[ND][31]}}, quo_reg[ND]};
            fold = 1'b0;
            if (z0 > 34'sd1073741824)
            begin
                z0 = z0 - 34'sd2147483648;
                fold = 1'b1;
            end
            else if (z0 < -34'sd1073741824)
            begin
                z0 = z0 + 34'sd2147483648;
                fold = 1'b1;
            end
            flip_reg[0] <= fold;
            cx_reg[0] <= CORDIC_GAIN;
            cy_reg[0] <= '0;
            cz_reg[0] <= z0;
            for (int i = 0; i < NC; i++)
            begin
                logic signed [33:0] a;
                a = (i < ATAN_LEN) ? $signed({2'b0, atan_turn(i)}) : 34'sd0;
                if (cz_reg[i] >= 0)
                begin
                    cx_reg[i+1] <= cx_reg[i] - (cy_reg[i] >>> i);
                    cy_reg[i+1] <= cy_reg[i] + (cx_reg[i] >>> i);
                    cz_reg[i+1] <= cz_reg[i] - a;
                end
                else
                begin
                    cx_reg[i+1] <= cx_reg[i] + (cy_reg[i] >>> i);
                    cy_reg[i+1] <= cy_reg[i] - (cx_reg[i] >>> i);
                    cz_reg[i+1] <= cz_reg[i] + a;
                end
                flip_reg[i+1] <= flip_reg[i];
            end
        end
    end

    // round to q1.15, saturate and unfold
    function automatic logic signed [16:0] to_q15(input logic signed [33:0] v,
                                                  input logic flip);
        logic signed [33:0] r;
        logic signed [16:0] q;
        r = (v + 34'sd16384) >>> 15;
        if (r > 34'sd32767)
        begin
            q = 17'sd32767;
        end
        else if (r < -34'sd32768)
        begin
            q = -17'sd32768;
        end
        else
        begin
            q = r[16:0];
        end
        return flip ? -q : q;
    endfunction

    logic signed [16:0] cs_reg, sn_reg;
    logic signed [48:0] pu_reg [3];
    logic signed [48:0] pv_reg [3];
    logic signed [49:0] acc_reg [3];
    logic signed [31:0] cen_reg [3];
    result_t            res_reg;

    localparam int SM = ND + 1 + NC + 1;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            logic signed [31:0] u [3];
            logic signed [31:0] v [3];
            logic signed [31:0] c [3];
            logic signed [49:0] t;
            cs_reg <= to_q15(cx_reg[NC], flip_reg[NC]);
            sn_reg <= to_q15(cy_reg[NC], flip_reg[NC]);
            u[0] = tsk_reg[SM].cos_axis_x;
            u[1] = tsk_reg[SM].cos_axis_y;
            u[2] = tsk_reg[SM].cos_axis_z;
            v[0] = tsk_reg[SM].sin_axis_x;
            v[1] = tsk_reg[SM].sin_axis_y;
            v[2] = tsk_reg[SM].sin_axis_z;
            c[0] = tsk_reg[SM+1].center_x;
            c[1] = tsk_reg[SM+1].center_y;
            c[2] = tsk_reg[SM+1].center_z;
            for (int k = 0; k < 3; k++)
            begin
                pu_reg[k]  <= 49'(u[k] * cs_reg);
                pv_reg[k]  <= 49'(v[k] * sn_reg);
                acc_reg[k] <= 50'(pu_reg[k]) + 50'(pv_reg[k]);
                cen_reg[k] <= c[k];
            end
            for (int k = 0; k < 3; k++)
            begin
                logic signed [31:0] r;
                t = ((acc_reg[k] + 50'sd16384) >>> 15) + 50'(cen_reg[k]);
                if (t > 50'sd2147483647)
                begin
                    r = 32'sh7fffffff;
                end
                else if (t < -50'sd2147483648)
                begin
                    r = 32'sh80000000;
                end
                else
                begin
                    r = t[31:0];
                end
                if (tsk_reg[NT-1].fault)
                begin
                    r = (k == 0) ? tsk_reg[NT-1].center_x :
                        (k == 1) ? tsk_reg[NT-1].center_y : tsk_reg[NT-1].center_z;
                end
                case (k)
                    0: res_reg.pos_x <= r;
                    1: res_reg.pos_y <= r;
                    default: res_reg.pos_z <= r;
                endcase
            end
            res_reg.period_fault <= tsk_reg[NT-1].fault;
        end
    end

    assign out_valid = vld_reg[NT];
    assign out_res   = res_reg;
endmodule

// ===== hw/rtl/ellipse_trajectory_point.sv =====
// top level of the ellipse trajectory point block
// a word passes through the front pipeline, task queue, back pipeline and result queue
// throughput: one word per cycle while no pipeline stalls, set by the fully pipelined
// divide and cordic stages
// both pipelines stall as a whole when their downstream queue has no room
// reset clears the valid bits and queue pointers; payload registers are not reset
module ellipse_trajectory_point import etp_pkg::*;
#(
    parameter int CORDIC_STEPS  = CORDIC_STEPS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [31:0]        time_ms,
    input  logic [31:0]        turn_period,
    input  logic signed [31:0] center_x,
    input  logic signed [31:0] center_y,
    input  logic signed [31:0] center_z,
    input  logic signed [31:0] cos_axis_x,
    input  logic signed [31:0] cos_axis_y,
    input  logic signed [31:0] cos_axis_z,
    input  logic signed [31:0] sin_axis_x,
    input  logic signed [31:0] sin_axis_y,
    input  logic signed [31:0] sin_axis_z,
    output logic               empty,
    input  logic               pop,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic signed [31:0] pos_z,
    output logic               period_fault
);
    // positions share one fixed-point format, so the datapath is format-free
    localparam int QCHK = FIFO_DEPTH;
    localparam int CW = $clog2(QCHK + 1);

    item_t   in_item;
    task_t   f_task, q_task;
    result_t b_res, r_res;
    logic    f_valid, b_valid;
    logic    tq_empty, rq_empty;
    logic [CW-1:0] tq_cnt, rq_cnt;
    logic    f_adv, b_adv, tq_rd;

    always_comb
    begin
        in_item.time_ms     = time_ms;
        in_item.turn_period = turn_period;
        in_item.center_x    = center_x;
        in_item.center_y    = center_y;
        in_item.center_z    = center_z;
        in_item.cos_axis_x  = cos_axis_x;
        in_item.cos_axis_y  = cos_axis_y;
        in_item.cos_axis_z  = cos_axis_z;
        in_item.sin_axis_x  = sin_axis_x;
        in_item.sin_axis_y  = sin_axis_y;
        in_item.sin_axis_z  = sin_axis_z;
    end

    // a pipeline moves when its output queue can take the word leaving it
    assign f_adv = !f_valid || (tq_cnt < CW'(QCHK));
    assign full  = !f_adv;
    assign tq_rd = !tq_empty && b_adv;
    assign b_adv = !b_valid || (rq_cnt < CW'(QCHK)) || (!rq_empty && pop);

    etp_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (push && f_adv),
        .in_item  (in_item),
        .advance  (f_adv),
        .out_valid(f_valid),
        .out_task (f_task)
    );

    etp_fifo #(.DEPTH(QCHK), .WIDTH($bits(task_t))) u_task_q
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (f_valid && f_adv),
        .wr_data(f_task),
        .rd_en  (tq_rd),
        .rd_data(q_task),
        .empty  (tq_empty),
        .count  (tq_cnt)
    );

    etp_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (tq_rd),
        .in_task  (q_task),
        .advance  (b_adv),
        .out_valid(b_valid),
        .out_res  (b_res)
    );

    // result queue, the oldest word sits on the output ports
    etp_fifo #(.DEPTH(QCHK), .WIDTH($bits(result_t))) u_res_q
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (b_valid && b_adv),
        .wr_data(b_res),
        .rd_en  (pop && !rq_empty),
        .rd_data(r_res),
        .empty  (rq_empty),
        .count  (rq_cnt)
    );

    assign empty        = rq_empty;
    assign pos_x        = r_res.pos_x;
    assign pos_y        = r_res.pos_y;
    assign pos_z        = r_res.pos_z;
    assign period_fault = r_res.period_fault;
endmodule
